// ----- hdl/plpg_pkg.sv -----
// Shared types and constants for the parametric line point generator.
// No dependencies; every other file in hdl/ imports this package.
package plpg_pkg;

  localparam int unsigned CoordW    = 5;
  localparam int unsigned CountW    = 7;
  localparam int unsigned GlyphW    = 8;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned DenW      = $clog2(MaxPoints);
  localparam int unsigned DivCntW   = $clog2(CoordW + 1);

  localparam logic [CountW-1:0] MinCount = CountW'(2);
  localparam logic [CountW-1:0] MaxCount = CountW'(MaxPoints);

  // Request to the shared divider: unsigned coordinate delta over count minus one
  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] dividend;
    logic [DenW-1:0]   divisor;
  } plpg_div_req_t;

  // Divider result, valid for one cycle when done is high
  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] quot;
    logic [DenW-1:0]   rem;
  } plpg_div_rsp_t;

endpackage

// ----- hdl/plpg_div.sv -----
// Shared restoring divider: one quotient bit per cycle over the coordinate width.
// Depends on plpg_pkg for the request and response structs.
module plpg_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  plpg_pkg::plpg_div_req_t req_i,
  output plpg_pkg::plpg_div_rsp_t rsp_o
);
  import plpg_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [CoordW-1:0]  dvd_q, dvd_d;
  logic [CoordW-1:0]  quot_q, quot_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [DenW-1:0]    dvs_q, dvs_d;
  logic [DenW:0]      trial;
  logic [DenW:0]      diff;
  logic               ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, dvd_q[CoordW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(CoordW);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[CoordW-2:0], 1'b0};
      quot_d = {quot_q[CoordW-2:0], ge};
      rem_d  = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      cnt_d  = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset; the datapath needs none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.divisor != '0)
    else $error("divider started with zero divisor");
`endif

endmodule

// ----- hdl/plpg_axis.sv -----
// One coordinate axis: floor quotient plus remainder accumulator, one point per step.
// Depends on plpg_pkg for widths and the divider response struct.
module plpg_axis (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  logic                   neg_i,
  input  logic [plpg_pkg::CoordW-1:0] origin_i,
  input  plpg_pkg::plpg_div_rsp_t div_i,
  input  logic [plpg_pkg::DenW-1:0]   den_i,
  input  logic                   step_i,
  output logic [plpg_pkg::CoordW-1:0] pos_o
);
  import plpg_pkg::*;

  localparam int unsigned StepW = CoordW + 2;

  logic [StepW-1:0]  dq_q, dq_d;
  logic [DenW-1:0]   dr_q, dr_d;
  logic [DenW-1:0]   r_q, r_d;
  logic [CoordW-1:0] pos_q, pos_d;
  logic [DenW:0]     rsum;
  logic              carry;
  logic [StepW-1:0]  pos_next;

  // Turn the unsigned quotient into a floor quotient and nonnegative remainder
  always_comb begin
    if (neg_i && div_i.rem != '0) begin
      dq_d = StepW'(0) - StepW'(div_i.quot) - StepW'(1);
      dr_d = den_i - div_i.rem;
    end else if (neg_i) begin
      dq_d = StepW'(0) - StepW'(div_i.quot);
      dr_d = '0;
    end else begin
      dq_d = StepW'(div_i.quot);
      dr_d = div_i.rem;
    end
  end

  // Advance: add the fractional step, carry one when the remainder wraps
  always_comb begin
    rsum     = {1'b0, r_q} + {1'b0, dr_q};
    carry    = rsum >= {1'b0, den_i};
    pos_next = StepW'(pos_q) + dq_q + StepW'(carry);
    r_d      = r_q;
    pos_d    = pos_q;
    if (load_i) begin
      r_d   = '0;
      pos_d = origin_i;
    end else if (step_i) begin
      r_d   = carry ? DenW'(rsum - {1'b0, den_i}) : rsum[DenW-1:0];
      pos_d = pos_next[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dq_q <= dq_d;
      dr_q <= dr_d;
    end
    r_q   <= r_d;
    pos_q <= pos_d;
  end

  assign pos_o = pos_q;

endmodule

// ----- hdl/parametric_line_point_generator.sv -----
// Parametric line point generator, top level: sequencer, shared divider, two axes.
// After a command is accepted, out_valid_o rises once two 5-bit divides have run in turn
// on the one shared divider, x first and then y; then one point per cycle while the
// output is taken. No command is taken while busy.
// Reset (rst_ni, async, active low) returns the sequencer to idle and drops out_valid_o.
module parametric_line_point_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [plpg_pkg::CoordW-1:0]   start_x_i,
  input  logic [plpg_pkg::CoordW-1:0]   start_y_i,
  input  logic [plpg_pkg::CoordW-1:0]   end_x_i,
  input  logic [plpg_pkg::CoordW-1:0]   end_y_i,
  input  logic [plpg_pkg::CountW-1:0]   point_count_i,
  input  logic [plpg_pkg::GlyphW-1:0]   glyph_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [plpg_pkg::CoordW-1:0]   point_x_o,
  output logic [plpg_pkg::CoordW-1:0]   point_y_o,
  output logic [plpg_pkg::GlyphW-1:0]   point_glyph_o,
  output logic                          last_point_o
);
  import plpg_pkg::*;

  typedef enum logic [1:0] {StIdle, StDivX, StDivY, StEmit} state_e;

  state_e            state_q, state_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [DenW-1:0]   idx_q, idx_d;
  logic [GlyphW-1:0] glyph_q, glyph_d;
  logic [CoordW-1:0] x0_q, x0_d, y0_q, y0_d;
  logic [CoordW-1:0] dy_mag_q, dy_mag_d;
  logic              x_neg_q, x_neg_d, y_neg_q, y_neg_d;

  logic              accept, out_fire, last;
  logic [CountW-1:0] count_clamped;
  logic [CountW-1:0] count_m1;
  logic              in_x_neg, in_y_neg;
  logic [CoordW-1:0] in_dx_mag, in_dy_mag;
  logic              load_x, load_y, step;

  plpg_div_req_t div_req;
  plpg_div_rsp_t div_rsp;

  assign accept   = in_valid_i && in_ready_o;
  assign last     = idx_q == den_q;
  assign out_fire = out_valid_o && out_ready_i;

  // Clamp the count and form the deltas of the incoming command
  always_comb begin
    if (point_count_i < MinCount) begin
      count_clamped = MinCount;
    end else if (point_count_i > MaxCount) begin
      count_clamped = MaxCount;
    end else begin
      count_clamped = point_count_i;
    end
    count_m1  = count_clamped - CountW'(1);
    in_x_neg  = end_x_i < start_x_i;
    in_y_neg  = end_y_i < start_y_i;
    in_dx_mag = in_x_neg ? start_x_i - end_x_i : end_x_i - start_x_i;
    in_dy_mag = in_y_neg ? start_y_i - end_y_i : end_y_i - start_y_i;
  end

  // Sequence: divide x, divide y, then emit one point per transaction
  always_comb begin
    state_d  = state_q;
    den_d    = den_q;
    idx_d    = idx_q;
    glyph_d  = glyph_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    dy_mag_d = dy_mag_q;
    x_neg_d  = x_neg_q;
    y_neg_d  = y_neg_q;
    load_x   = 1'b0;
    load_y   = 1'b0;
    step     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = in_dx_mag;
    div_req.divisor  = count_m1[DenW-1:0];
    case (state_q)
      StIdle: begin
        if (accept) begin
          den_d    = count_m1[DenW-1:0];
          glyph_d  = glyph_i;
          x0_d     = start_x_i;
          y0_d     = start_y_i;
          dy_mag_d = in_dy_mag;
          x_neg_d  = in_x_neg;
          y_neg_d  = in_y_neg;
          div_req.start = 1'b1;
          state_d  = StDivX;
        end
      end
      StDivX: begin
        div_req.dividend = dy_mag_q;
        div_req.divisor  = den_q;
        if (div_rsp.done) begin
          load_x        = 1'b1;
          div_req.start = 1'b1;
          state_d       = StDivY;
        end
      end
      StDivY: begin
        div_req.dividend = dy_mag_q;
        div_req.divisor  = den_q;
        if (div_rsp.done) begin
          load_y  = 1'b1;
          idx_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        div_req.dividend = dy_mag_q;
        div_req.divisor  = den_q;
        if (out_fire) begin
          if (last) begin
            state_d = StIdle;
          end else begin
            step  = 1'b1;
            idx_d = idx_q + DenW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q    <= den_d;
    idx_q    <= idx_d;
    glyph_q  <= glyph_d;
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    dy_mag_q <= dy_mag_d;
    x_neg_q  <= x_neg_d;
    y_neg_q  <= y_neg_d;
  end

  plpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  plpg_axis u_axis_x (
    .clk_i    (clk_i),
    .load_i   (load_x),
    .neg_i    (x_neg_q),
    .origin_i (x0_q),
    .div_i    (div_rsp),
    .den_i    (den_q),
    .step_i   (step),
    .pos_o    (point_x_o)
  );

  plpg_axis u_axis_y (
    .clk_i    (clk_i),
    .load_i   (load_y),
    .neg_i    (y_neg_q),
    .origin_i (y0_q),
    .div_i    (div_rsp),
    .den_i    (den_q),
    .step_i   (step),
    .pos_o    (point_y_o)
  );

  assign in_ready_o    = state_q == StIdle;
  assign out_valid_o   = state_q == StEmit;
  assign point_glyph_o = glyph_q;
  assign last_point_o  = last;

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q <= den_q)
    else $error("point index beyond count");
  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_point_o |=> in_ready_o && !out_valid_o)
    else $error("sequencer did not return to idle after final point");
  a_first_point_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> point_x_o == x0_q && point_y_o == y0_q && idx_q == '0)
    else $error("first point is not the start endpoint");
  a_div_only_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == StDivX || state_q == StDivY)
    else $error("divider result arrived outside a divide state");
`endif

endmodule
